// ===== design/dsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_pkg: shared definitions for the damped spring force block
// Register indexes, reset values, field widths and the pipeline stage counts.
// ----------------------------------------------------------------------------
package dsf_pkg;

  // Field widths.
  localparam int unsigned DW  = 32;
  localparam int unsigned CW  = 31;
  localparam int unsigned CIW = 2;

  // Configuration register indexes.
  localparam logic [CIW-1:0] CFG_REST  = 2'd0;
  localparam logic [CIW-1:0] CFG_STIFF = 2'd1;
  localparam logic [CIW-1:0] CFG_DAMP  = 2'd2;

  // Register reset values (Q16.16).
  localparam logic [CW-1:0] RST_REST  = 31'd65536;
  localparam logic [CW-1:0] RST_STIFF = 31'd65536;
  localparam logic [CW-1:0] RST_DAMP  = 31'd0;

  // One root bit per square root stage, one quotient bit per divider stage.
  localparam int unsigned SQ_STEPS  = 33;
  localparam int unsigned DIV_STEPS = 17;

  // Output saturation limits.
  localparam logic [DW-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [DW-1:0] NEG_LIMIT = 32'h8000_0000;

  // Per-item data carried alongside the root and quotient stages.
  typedef struct packed {
    logic [32:0] mx;
    logic [32:0] my;
    logic        sdx;
    logic        sdy;
    logic [32:0] wmx;
    logic [32:0] wmy;
    logic        swx;
    logic        swy;
    logic        zero;
  } carry_t;

endpackage

// ===== design/damped_spring_force.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_spring_force: spring plus damper force between two particles
// Computes the Q16.16 force on particle A from both positions and velocities,
// with a pipelined square root and pipelined restoring dividers.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | in_pos_{a,b}_{x,y}, in_vel_{a,b}_{x,y}
//  out     | out_valid / out_ready| out_force_x/y, out_coincident, out_saturated
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One request enters per cycle while the output is not stalled; each request
// passes through the 33 square root stages and the divider stages.
// The whole pipeline advances together whenever the output register is
// empty or being taken; a stall freezes every stage. rst_n clears the valid
// bits and loads the register reset values. Configuration writes are always
// taken.
module damped_spring_force
  import dsf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [DW-1:0] in_pos_a_x,
  input  logic signed [DW-1:0] in_pos_a_y,
  input  logic signed [DW-1:0] in_pos_b_x,
  input  logic signed [DW-1:0] in_pos_b_y,
  input  logic signed [DW-1:0] in_vel_a_x,
  input  logic signed [DW-1:0] in_vel_a_y,
  input  logic signed [DW-1:0] in_vel_b_x,
  input  logic signed [DW-1:0] in_vel_b_y,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [DW-1:0] out_force_x,
  output logic signed [DW-1:0] out_force_y,
  output logic                out_coincident,
  output logic                out_saturated,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CIW-1:0]      cfg_index,
  input  logic [DW-1:0]       cfg_wdata
);

  // Configuration registers.
  logic [CW-1:0] rest_r, stiff_r, damp_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= RST_REST;
      stiff_r <= RST_STIFF;
      damp_r  <= RST_DAMP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_REST:  rest_r  <= cfg_wdata[CW-1:0];
        CFG_STIFF: stiff_r <= cfg_wdata[CW-1:0];
        CFG_DAMP:  damp_r  <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output register can move.
  logic en;
  logic f_v_r;

  assign en       = out_ready | ~f_v_r;
  assign in_ready = en;

  // Stage 1: separation and relative velocity.
  logic        s1_v_r;
  logic [32:0] dx_r, dy_r, wx_r, wy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= {in_pos_b_x[31], in_pos_b_x} - {in_pos_a_x[31], in_pos_a_x};
      dy_r <= {in_pos_b_y[31], in_pos_b_y} - {in_pos_a_y[31], in_pos_a_y};
      wx_r <= {in_vel_b_x[31], in_vel_b_x} - {in_vel_a_x[31], in_vel_a_x};
      wy_r <= {in_vel_b_y[31], in_vel_b_y} - {in_vel_a_y[31], in_vel_a_y};
    end
  end

  // Stage 2: magnitudes and squares.
  logic        s2_v_r;
  logic [65:0] sqx_r, sqy_r;
  carry_t      s2_c_r;
  carry_t      s2_c_nxt;

  always_comb begin
    s2_c_nxt.sdx  = dx_r[32];
    s2_c_nxt.sdy  = dy_r[32];
    s2_c_nxt.swx  = wx_r[32];
    s2_c_nxt.swy  = wy_r[32];
    s2_c_nxt.mx   = dx_r[32] ? (33'd0 - dx_r) : dx_r;
    s2_c_nxt.my   = dy_r[32] ? (33'd0 - dy_r) : dy_r;
    s2_c_nxt.wmx  = wx_r[32] ? (33'd0 - wx_r) : wx_r;
    s2_c_nxt.wmy  = wy_r[32] ? (33'd0 - wy_r) : wy_r;
    s2_c_nxt.zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_c_r <= s2_c_nxt;
      sqx_r  <= 66'(s2_c_nxt.mx) * 66'(s2_c_nxt.mx);
      sqy_r  <= 66'(s2_c_nxt.my) * 66'(s2_c_nxt.my);
    end
  end

  // Square root pipeline: entry 0 holds the squared distance, each later
  // entry has resolved one more root bit.
  logic        sq_v_r    [0:SQ_STEPS];
  logic [65:0] sq_rad_r  [0:SQ_STEPS];
  logic [35:0] sq_rem_r  [0:SQ_STEPS];
  logic [32:0] sq_root_r [0:SQ_STEPS];
  carry_t      sq_c_r    [0:SQ_STEPS];
  logic [35:0] sq_rem_nxt  [1:SQ_STEPS];
  logic [32:0] sq_root_nxt [1:SQ_STEPS];
  carry_t      sq_c0_nxt;

  always_comb begin
    sq_c0_nxt      = s2_c_r;
    sq_c0_nxt.zero = ((sqx_r + sqy_r) == 66'd0);
  end

  always_comb begin
    logic [35:0] rem2;
    logic [35:0] trial;
    for (int k = 1; k <= SQ_STEPS; k++) begin
      rem2  = {sq_rem_r[k-1][33:0], sq_rad_r[k-1][65:64]};
      trial = {1'b0, sq_root_r[k-1], 2'b01};
      if (rem2 >= trial) begin
        sq_rem_nxt[k]  = rem2 - trial;
        sq_root_nxt[k] = {sq_root_r[k-1][31:0], 1'b1};
      end else begin
        sq_rem_nxt[k]  = rem2;
        sq_root_nxt[k] = {sq_root_r[k-1][31:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rad_r[0]  <= sqx_r + sqy_r;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_c_r[0]    <= sq_c0_nxt;
      for (int k = 1; k <= SQ_STEPS; k++) begin
        sq_rad_r[k]  <= {sq_rad_r[k-1][63:0], 2'b00};
        sq_rem_r[k]  <= sq_rem_nxt[k];
        sq_root_r[k] <= sq_root_nxt[k];
        sq_c_r[k]    <= sq_c_r[k-1];
      end
    end
  end

  // Divider pipeline: unit direction magnitudes (m << 16) / dist, one
  // quotient bit per stage for each axis.
  logic        dv_v_r    [0:DIV_STEPS];
  logic [32:0] dv_rx_r   [0:DIV_STEPS];
  logic [32:0] dv_ry_r   [0:DIV_STEPS];
  logic        dv_bx_r   [0:DIV_STEPS];
  logic        dv_by_r   [0:DIV_STEPS];
  logic [16:0] dv_qx_r   [0:DIV_STEPS];
  logic [16:0] dv_qy_r   [0:DIV_STEPS];
  logic [32:0] dv_dist_r [0:DIV_STEPS];
  carry_t      dv_c_r    [0:DIV_STEPS];
  logic [32:0] dv_rx_nxt [1:DIV_STEPS];
  logic [32:0] dv_ry_nxt [1:DIV_STEPS];
  logic        dv_gx     [1:DIV_STEPS];
  logic        dv_gy     [1:DIV_STEPS];

  always_comb begin
    logic [33:0] rx2;
    logic [33:0] ry2;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      rx2 = {dv_rx_r[k-1], dv_bx_r[k-1]};
      ry2 = {dv_ry_r[k-1], dv_by_r[k-1]};
      dv_gx[k] = (rx2 >= {1'b0, dv_dist_r[k-1]});
      dv_gy[k] = (ry2 >= {1'b0, dv_dist_r[k-1]});
      dv_rx_nxt[k] = dv_gx[k] ? 33'(rx2 - {1'b0, dv_dist_r[k-1]}) : rx2[32:0];
      dv_ry_nxt[k] = dv_gy[k] ? 33'(ry2 - {1'b0, dv_dist_r[k-1]}) : ry2[32:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rx_r[0]   <= {1'b0, sq_c_r[SQ_STEPS].mx[32:1]};
      dv_ry_r[0]   <= {1'b0, sq_c_r[SQ_STEPS].my[32:1]};
      dv_bx_r[0]   <= sq_c_r[SQ_STEPS].mx[0];
      dv_by_r[0]   <= sq_c_r[SQ_STEPS].my[0];
      dv_qx_r[0]   <= '0;
      dv_qy_r[0]   <= '0;
      dv_dist_r[0] <= sq_root_r[SQ_STEPS];
      dv_c_r[0]    <= sq_c_r[SQ_STEPS];
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dv_rx_r[k]   <= dv_rx_nxt[k];
        dv_ry_r[k]   <= dv_ry_nxt[k];
        dv_bx_r[k]   <= 1'b0;
        dv_by_r[k]   <= 1'b0;
        dv_qx_r[k]   <= {dv_qx_r[k-1][15:0], dv_gx[k]};
        dv_qy_r[k]   <= {dv_qy_r[k-1][15:0], dv_gy[k]};
        dv_dist_r[k] <= dv_dist_r[k-1];
        dv_c_r[k]    <= dv_c_r[k-1];
      end
    end
  end

  // Stage A: spring displacement and velocity products along the direction.
  logic        a_v_r;
  logic [33:0] a_disp_mag_r;
  logic        a_disp_neg_r;
  logic [49:0] a_pdx_r, a_pdy_r;
  logic        a_pdx_neg_r, a_pdy_neg_r;
  logic [16:0] a_umx_r, a_umy_r;
  logic        a_sdx_r, a_sdy_r, a_zero_r;
  logic [34:0] a_disp;
  carry_t      dv_last;

  assign dv_last = dv_c_r[DIV_STEPS];
  assign a_disp  = {2'b00, dv_dist_r[DIV_STEPS]} - {4'b0000, rest_r};

  always_ff @(posedge clk) begin
    if (en) begin
      a_disp_neg_r <= a_disp[34];
      a_disp_mag_r <= a_disp[34] ? 34'(35'd0 - a_disp) : a_disp[33:0];
      a_pdx_r      <= 50'(dv_qx_r[DIV_STEPS]) * 50'(dv_last.wmx);
      a_pdy_r      <= 50'(dv_qy_r[DIV_STEPS]) * 50'(dv_last.wmy);
      a_pdx_neg_r  <= dv_last.sdx ^ dv_last.swx;
      a_pdy_neg_r  <= dv_last.sdy ^ dv_last.swy;
      a_umx_r      <= dv_qx_r[DIV_STEPS];
      a_umy_r      <= dv_qy_r[DIV_STEPS];
      a_sdx_r      <= dv_last.sdx;
      a_sdy_r      <= dv_last.sdy;
      a_zero_r     <= dv_last.zero;
    end
  end

  // Stage B: spring term and dot product of direction and velocity.
  logic        b_v_r;
  logic [51:0] b_spring_r;
  logic [33:0] b_dot_mag_r;
  logic        b_dot_neg_r;
  logic [16:0] b_umx_r, b_umy_r;
  logic        b_sdx_r, b_sdy_r, b_zero_r;
  logic [64:0] b_sp_prod;
  logic [50:0] b_sx, b_sy;
  logic [51:0] b_dsum, b_dabs;

  assign b_sp_prod = 65'(a_disp_mag_r) * 65'(stiff_r);
  assign b_sx      = a_pdx_neg_r ? (51'd0 - 51'(a_pdx_r)) : 51'(a_pdx_r);
  assign b_sy      = a_pdy_neg_r ? (51'd0 - 51'(a_pdy_r)) : 51'(a_pdy_r);
  assign b_dsum    = {b_sx[50], b_sx} + {b_sy[50], b_sy};
  assign b_dabs    = b_dsum[51] ? (52'd0 - b_dsum) : b_dsum;

  always_ff @(posedge clk) begin
    if (en) begin
      b_spring_r  <= a_disp_neg_r ? (52'd0 - 52'(b_sp_prod[64:16]))
                                  : 52'(b_sp_prod[64:16]);
      b_dot_mag_r <= b_dabs[49:16];
      b_dot_neg_r <= b_dsum[51];
      b_umx_r     <= a_umx_r;
      b_umy_r     <= a_umy_r;
      b_sdx_r     <= a_sdx_r;
      b_sdy_r     <= a_sdy_r;
      b_zero_r    <= a_zero_r;
    end
  end

  // Stage C: damping term.
  logic        c_v_r;
  logic [51:0] c_spring_r, c_damp_r;
  logic [16:0] c_umx_r, c_umy_r;
  logic        c_sdx_r, c_sdy_r, c_zero_r;
  logic [64:0] c_dp_prod;

  assign c_dp_prod = 65'(b_dot_mag_r) * 65'(damp_r);

  always_ff @(posedge clk) begin
    if (en) begin
      c_spring_r <= b_spring_r;
      c_damp_r   <= b_dot_neg_r ? (52'd0 - 52'(c_dp_prod[64:16]))
                                : 52'(c_dp_prod[64:16]);
      c_umx_r    <= b_umx_r;
      c_umy_r    <= b_umy_r;
      c_sdx_r    <= b_sdx_r;
      c_sdy_r    <= b_sdy_r;
      c_zero_r   <= b_zero_r;
    end
  end

  // Stage D: total magnitude and sign.
  logic        d_v_r;
  logic [50:0] d_tot_mag_r;
  logic        d_negx_r, d_negy_r;
  logic [16:0] d_umx_r, d_umy_r;
  logic        d_zero_r;
  logic [51:0] d_total, d_tabs;

  assign d_total = c_spring_r + c_damp_r;
  assign d_tabs  = d_total[51] ? (52'd0 - d_total) : d_total;

  always_ff @(posedge clk) begin
    if (en) begin
      d_tot_mag_r <= d_tabs[50:0];
      d_negx_r    <= d_total[51] ^ c_sdx_r;
      d_negy_r    <= d_total[51] ^ c_sdy_r;
      d_umx_r     <= c_umx_r;
      d_umy_r     <= c_umy_r;
      d_zero_r    <= c_zero_r;
    end
  end

  // Stage E: projection onto each axis.
  logic        e_v_r;
  logic [51:0] e_fmx_r, e_fmy_r;
  logic        e_negx_r, e_negy_r, e_zero_r;
  logic [67:0] e_px, e_py;

  assign e_px = 68'(d_tot_mag_r) * 68'(d_umx_r);
  assign e_py = 68'(d_tot_mag_r) * 68'(d_umy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      e_fmx_r  <= e_px[67:16];
      e_fmy_r  <= e_py[67:16];
      e_negx_r <= d_negx_r;
      e_negy_r <= d_negy_r;
      e_zero_r <= d_zero_r;
    end
  end

  // Stage F: saturate and hold the result in the output register.
  logic [DW-1:0] f_fx_r, f_fy_r;
  logic          f_coinc_r, f_sat_r;
  logic [DW-1:0] f_fx, f_fy;
  logic          f_satx, f_saty;

  always_comb begin
    if (e_negx_r) begin
      f_satx = (e_fmx_r > 52'(NEG_LIMIT));
      f_fx   = f_satx ? NEG_LIMIT : (32'd0 - e_fmx_r[31:0]);
    end else begin
      f_satx = (e_fmx_r > 52'(POS_LIMIT));
      f_fx   = f_satx ? POS_LIMIT : e_fmx_r[31:0];
    end
    if (e_negy_r) begin
      f_saty = (e_fmy_r > 52'(NEG_LIMIT));
      f_fy   = f_saty ? NEG_LIMIT : (32'd0 - e_fmy_r[31:0]);
    end else begin
      f_saty = (e_fmy_r > 52'(POS_LIMIT));
      f_fy   = f_saty ? POS_LIMIT : e_fmy_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_fx_r    <= e_zero_r ? '0 : f_fx;
      f_fy_r    <= e_zero_r ? '0 : f_fy;
      f_coinc_r <= e_zero_r;
      f_sat_r   <= ~e_zero_r & (f_satx | f_saty);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) sq_v_r[k] <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_v_r[k] <= 1'b0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      sq_v_r[0] <= s2_v_r;
      for (int k = 1; k <= SQ_STEPS; k++) sq_v_r[k] <= sq_v_r[k-1];
      dv_v_r[0] <= sq_v_r[SQ_STEPS];
      for (int k = 1; k <= DIV_STEPS; k++) dv_v_r[k] <= dv_v_r[k-1];
      a_v_r <= dv_v_r[DIV_STEPS];
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  assign out_valid      = f_v_r;
  assign out_force_x    = f_fx_r;
  assign out_force_y    = f_fy_r;
  assign out_coincident = f_coinc_r;
  assign out_saturated  = f_sat_r;

endmodule

// ===== design/dsf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsf_checker: port-level assertions for the damped spring force block
// Watches the handshakes and the result flags over time.
// ----------------------------------------------------------------------------
module dsf_checker
  import dsf_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [DW-1:0] out_force_x,
  input logic signed [DW-1:0] out_force_y,
  input logic                out_coincident,
  input logic                out_saturated
);

  // A waiting result stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_force_x) &&
      $stable(out_force_y))
    else $error("result changed while stalled");

  // The pipeline takes a request exactly when its output can move.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (out_ready || !out_valid))
    else $error("input ready does not follow the output stall");

  // Coincident particles give a zero, unsaturated force.
  a_coinc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coincident |->
      out_force_x == 0 && out_force_y == 0 && !out_saturated)
    else $error("coincident result carries a force");

  // A saturated result has a component at a limit.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_force_x == POS_LIMIT || out_force_x == NEG_LIMIT ||
      out_force_y == POS_LIMIT || out_force_y == NEG_LIMIT)
    else $error("saturated flag without a clamped component");

endmodule

bind damped_spring_force dsf_checker u_dsf_checker (.*);

// ===== tb/tb_damped_spring_force.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_damped_spring_force: self-checking bench for the damped spring force
// Feeds particle pairs through a valid/ready driver, predicts each force with
// an exact 128-bit arithmetic model, and compares every result in order.
// Register settings change between phases while the pipeline is drained.
// ----------------------------------------------------------------------------
module tb_damped_spring_force;
  import dsf_pkg::*;

  localparam int unsigned LATENCY = 60;

  typedef struct packed {
    logic [DW-1:0] pax, pay, pbx, pby, vax, vay, vbx, vby;
  } pair_t;

  typedef struct packed {
    logic [DW-1:0] fx, fy;
    logic          coin, sat;
  } force_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pair_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DW-1:0] out_force_x, out_force_y;
  logic out_coincident, out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIW-1:0] cfg_index = CFG_REST;
  logic [DW-1:0] cfg_wdata = '0;
  logic in_ready_seen = 1'b0;

  pair_t  pending_pairs[$];
  force_t expected_forces[$];
  logic [CW-1:0] rest_len, stiff, damp_gain;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit failed = 1'b0;

  always #5 clk = ~clk;

  damped_spring_force dut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_pos_a_x(in_req.pax), .in_pos_a_y(in_req.pay),
    .in_pos_b_x(in_req.pbx), .in_pos_b_y(in_req.pby),
    .in_vel_a_x(in_req.vax), .in_vel_a_y(in_req.vay),
    .in_vel_b_x(in_req.vbx), .in_vel_b_y(in_req.vby),
    .out_valid, .out_ready, .out_force_x, .out_force_y,
    .out_coincident, .out_saturated,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  // (a * b) >> 16 with the same far-out saturation as the block's multiplier.
  function automatic logic [127:0] scale_q16(logic [127:0] a, logic [127:0] b);
    logic [127:0] am;
    logic [127:0] hi;
    am = a & ((128'd1 << 51) - 1);
    hi = (am >> 32) * b[31:0];
    if (hi >= (128'd1 << 47)) return 128'd1 << 62;
    return (hi << 16) + (((am & 128'hFFFF_FFFF) * b[31:0]) >> 16);
  endfunction

  // Floor square root, bit by bit.
  function automatic logic [127:0] floor_root(logic [127:0] v);
    logic [127:0] rem, root, trial;
    rem = 0;
    root = 0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      trial = (root << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 128'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Sign-magnitude to a clamped 32-bit component.
  function automatic logic [DW-1:0] clamp_force(bit neg, logic [127:0] m, inout logic sat);
    if (neg) begin
      if (m > 128'h8000_0000) begin
        sat = 1'b1;
        m = 128'h8000_0000;
      end
      return DW'(-m);
    end
    if (m > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      m = 128'h7FFF_FFFF;
    end
    return DW'(m);
  endfunction

  function automatic logic [127:0] mag(logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Predicted force on particle A for one request.
  function automatic force_t spring_force(pair_t p);
    logic signed [127:0] dx, dy, wx, wy, ux, uy, disp, spring, dot, dmp, total;
    logic [127:0] mx, my, sep_len, umx, umy, tm, m;
    force_t f;
    dx = $signed(p.pbx) - $signed(p.pax);
    dy = $signed(p.pby) - $signed(p.pay);
    wx = $signed(p.vbx) - $signed(p.vax);
    wy = $signed(p.vby) - $signed(p.vay);
    mx = mag(dx);
    my = mag(dy);
    f = '0;
    if (mx == 0 && my == 0) begin
      f.coin = 1'b1;
      return f;
    end
    sep_len = floor_root(mx * mx + my * my);
    umx = (mx << 16) / sep_len;
    umy = (my << 16) / sep_len;
    ux = dx < 0 ? -$signed(umx) : $signed(umx);
    uy = dy < 0 ? -$signed(umy) : $signed(umy);
    disp = $signed(sep_len) - $signed({97'd0, rest_len});
    m = scale_q16(mag(disp), {97'd0, stiff});
    spring = disp < 0 ? -$signed(m) : $signed(m);
    dot = ux * wx + uy * wy;
    dot = dot < 0 ? -$signed(mag(dot) >> 16) : $signed(dot >> 16);
    m = scale_q16(mag(dot), {97'd0, damp_gain});
    dmp = dot < 0 ? -$signed(m) : $signed(m);
    total = spring + dmp;
    tm = mag(total);
    f.fx = clamp_force((total < 0) != (dx < 0), scale_q16(tm, umx), f.sat);
    f.fy = clamp_force((total < 0) != (dy < 0), scale_q16(tm, umy), f.sat);
    return f;
  endfunction

  function automatic logic [DW-1:0] any_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return DW'($signed($urandom_range(0, 262144)) - 131072);
      default: return $urandom();
    endcase
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    logic [DW-1:0] base;
    p = {any_word(), any_word(), any_word(), any_word(),
         any_word(), any_word(), any_word(), any_word()};
    // Mostly nearby particles so the spring and damper terms stay in range.
    if ($urandom_range(0, 3) != 0) begin
      base = $urandom();
      p.pax = base;
      p.pbx = base + DW'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      base = $urandom();
      p.pay = base;
      p.pby = base + DW'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      p.vax = DW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      p.vbx = DW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      p.vay = DW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      p.vby = DW'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    end
    if ($urandom_range(0, 30) == 0) begin
      p.pbx = p.pax;
      p.pby = p.pay;
    end
    return p;
  endfunction

  // Request driver: changes inputs on the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_req <= pending_pairs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  // Acceptance seen at the last rising edge, with the prediction made there.
  always @(posedge clk) begin
    in_ready_seen <= 1'b0;
    if (rst_n && in_valid && in_ready) begin
      expected_forces.push_back(spring_force(in_req));
      in_ready_seen <= 1'b1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    force_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_forces.size() == 0) begin
        $error("result with no request outstanding");
        failed <= 1'b1;
      end else begin
        e = expected_forces.pop_front();
        if (out_force_x !== e.fx) begin
          $error("force_x expected %h got %h", e.fx, out_force_x);
          failed <= 1'b1;
        end
        if (out_force_y !== e.fy) begin
          $error("force_y expected %h got %h", e.fy, out_force_y);
          failed <= 1'b1;
        end
        if (out_coincident !== e.coin) begin
          $error("coincident expected %b got %b", e.coin, out_coincident);
          failed <= 1'b1;
        end
        if (out_saturated !== e.sat) begin
          $error("saturated expected %b got %b", e.sat, out_saturated);
          failed <= 1'b1;
        end
      end
    end
  end

  task automatic write_reg(logic [CIW-1:0] idx, logic [DW-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REST:  rest_len = val[CW-1:0];
      CFG_STIFF: stiff = val[CW-1:0];
      default:   damp_gain = val[CW-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid || expected_forces.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Stimulus and phase sequencing.
  initial begin
    logic [DW-1:0] g[3];
    rest_len = RST_REST;
    stiff = RST_STIFF;
    damp_gain = RST_DAMP;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, coincident particles, clamped forces.
    pending_pairs.push_back('0);
    pending_pairs.push_back({32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0,
                             32'h0, 32'h0, 32'h0, 32'h0});
    pending_pairs.push_back({32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_pairs.push_back({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                             32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF});
    pending_pairs.push_back({32'h0, 32'h0, 32'h0000_0001, 32'h0,
                             32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0});
    pending_pairs.push_back({32'h0, 32'h0, 32'h0, 32'hFFFF_0000,
                             32'h0, 32'h0001_0000, 32'h0, 32'hFFFF_0000});
    pending_pairs.push_back({32'h0, 32'h0, 32'h0003_0000, 32'h0004_0000,
                             32'h0, 32'h0, 32'h0002_0000, 32'h0});
    for (int i = 0; i < 6; i++) pending_pairs.push_back(random_pair());
    drain();

    // Random phases across settings and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: g = '{32'h0, 32'h0, 32'h0};
        1: g = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        2: g = '{32'h0002_0000, 32'h0000_8000, 32'h0001_0000};
        3: g = '{32'h0, 32'h7FFF_FFFF, 32'h0};
        default: g = '{$urandom_range(0, 1 << 22), $urandom_range(0, 1 << 20),
                       $urandom_range(0, 1 << 19)};
      endcase
      write_reg(CFG_REST, g[0]);
      write_reg(CFG_STIFF, g[1]);
      write_reg(CFG_DAMP, g[2]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 73; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 73; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int i = 0; i < 185; i++) pending_pairs.push_back(random_pair());
      drain();
    end

    if (!failed) begin
      $display("** damped_spring_force: PASSED **");
    end else begin
      $display("** damped_spring_force: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("** damped_spring_force: FAILED **");
    $finish;
  end

endmodule

// ===== damped_spring_force.f =====
design/dsf_pkg.sv
design/damped_spring_force.sv
design/dsf_checker.sv
tb/tb_damped_spring_force.sv
